>>> design/bsc_pkg.sv
package bsc_pkg;

  localparam int SIG_COUNT  = 9;
  localparam int WIN_DEPTH  = 9;
  localparam int PORT_COUNT = 14;
  localparam int MAX_BANNER = 200;
  localparam int KEPT_W     = $clog2(MAX_BANNER + 1);
  localparam int CODE_W     = 5;
  localparam int PORT_W     = 16;
  localparam int LEN_W      = 8;
  localparam int TEXT_W     = 8 * (WIN_DEPTH + 1);

  typedef logic [7:0]           char_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [KEPT_W-1:0]    kept_t;
  typedef logic [SIG_COUNT-1:0] sig_vec_t;
  typedef logic [PORT_W-1:0]    port_t;
  typedef logic [LEN_W-1:0]     len_t;

  localparam char_t CHAR_LF    = 8'd10;
  localparam char_t CHAR_CR    = 8'd13;
  localparam char_t CHAR_SPACE = 8'd32;
  localparam char_t CHAR_FIRST = 8'd32;
  localparam char_t CHAR_LAST  = 8'd126;

  localparam code_t CODE_UNKNOWN  = 5'd0;
  localparam code_t CODE_FTP      = 5'd1;
  localparam code_t CODE_WEB_A    = 5'd2;
  localparam code_t CODE_HTTP     = 5'd3;
  localparam code_t CODE_SQL_M    = 5'd4;
  localparam code_t CODE_SQL_P    = 5'd5;
  localparam code_t CODE_VNC      = 5'd6;
  localparam code_t CODE_SMTP     = 5'd7;
  localparam code_t CODE_SSH      = 5'd8;
  localparam code_t CODE_WEB_N    = 5'd9;
  localparam code_t CODE_TELNET   = 5'd10;
  localparam code_t CODE_DNS      = 5'd11;
  localparam code_t CODE_HTTPS    = 5'd12;
  localparam code_t CODE_RDP      = 5'd13;
  localparam code_t CODE_KV       = 5'd14;
  localparam code_t CODE_HTTP_ALT = 5'd15;
  localparam code_t CODE_DOC_DB   = 5'd16;

  // Signature text, right-justified: byte 0 is the final character.
  localparam logic [TEXT_W-1:0] SIG_TEXT [SIG_COUNT] = '{
    TEXT_W'("220"),
    TEXT_W'(80'h417061636865),
    TEXT_W'("HTTP/"),
    TEXT_W'(80'h4D7953514C),
    TEXT_W'(80'h506F737467726553514C),
    TEXT_W'("RFB"),
    TEXT_W'("SMTP"),
    TEXT_W'("SSH-"),
    TEXT_W'(80'h6E67696E78)
  };

  localparam int SIG_LEN [SIG_COUNT] = '{3, 6, 5, 5, 10, 3, 4, 4, 5};

  localparam code_t SIG_CODE [SIG_COUNT] = '{
    CODE_FTP, CODE_WEB_A, CODE_HTTP, CODE_SQL_M, CODE_SQL_P,
    CODE_VNC, CODE_SMTP, CODE_SSH, CODE_WEB_N
  };

  localparam port_t PORT_NUM [PORT_COUNT] = '{
    16'd21, 16'd22, 16'd23, 16'd25, 16'd53, 16'd80, 16'd443,
    16'd3306, 16'd3389, 16'd5432, 16'd5900, 16'd6379, 16'd8080, 16'd27017
  };

  localparam code_t PORT_CODE [PORT_COUNT] = '{
    CODE_FTP, CODE_SSH, CODE_TELNET, CODE_SMTP, CODE_DNS, CODE_HTTP, CODE_HTTPS,
    CODE_SQL_M, CODE_RDP, CODE_SQL_P, CODE_VNC, CODE_KV, CODE_HTTP_ALT, CODE_DOC_DB
  };

  typedef struct packed {
    char_t [SIG_COUNT-1:0] chr;
    sig_vec_t              care;
  } cell_ref_t;

  typedef struct packed {
    logic     load;
    sig_vec_t hits;
    kept_t    kept;
    port_t    port;
  } decide_req_t;

  // Expected character of every signature at one window position.
  function automatic cell_ref_t cell_ref(input int pos);
    cell_ref_t r;
    for (int k = 0; k < SIG_COUNT; k++) begin
      r.chr[k]  = SIG_TEXT[k][8*(pos+1) +: 8];
      r.care[k] = (pos + 1 < SIG_LEN[k]);
    end
    return r;
  endfunction

  function automatic code_t port_lookup(input port_t p);
    code_t c;
    c = CODE_UNKNOWN;
    for (int k = 0; k < PORT_COUNT; k++) begin
      if (PORT_NUM[k] == p) c = PORT_CODE[k];
    end
    return c;
  endfunction

endpackage

>>> design/bsc_if.sv
interface bsc_in_if;
  logic              valid;
  logic              ready;
  bsc_pkg::char_t    raw_byte;
  logic              has_byte;
  logic              last;
  bsc_pkg::port_t    port;

  modport source (output valid, raw_byte, has_byte, last, port, input ready);
  modport sink   (input valid, raw_byte, has_byte, last, port, output ready);
endinterface

interface bsc_out_if;
  logic              valid;
  logic              ready;
  bsc_pkg::code_t    service_code;
  logic              from_banner;
  bsc_pkg::len_t     banner_length;

  modport source (output valid, service_code, from_banner, banner_length, input ready);
  modport sink   (input valid, service_code, from_banner, banner_length, output ready);
endinterface

>>> design/banner_service_classifier.sv
// Classifies a connection's reply from its raw bytes, one byte per beat, and gives one
// service code on the beat marked last. A beat is taken every cycle while the result
// register is empty or being drained, so the sustained rate is one byte per cycle; the
// result is valid in the cycle after the last beat. Printable bytes are kept, CR and LF
// count as spaces, and only the first 200 cleaned characters are matched. The recent
// characters sit in a row of nine window cells that shift once per kept character, each
// comparing its character against every signature; a signature hit is sticky until the
// last beat, after which the window, the hits and the count are cleared.
module banner_service_classifier (
  input  logic        clk,
  input  logic        rst,
  bsc_in_if.sink      bytes,
  bsc_out_if.source   result
);

  bsc_pkg::char_t      tap    [bsc_pkg::WIN_DEPTH];
  bsc_pkg::sig_vec_t   cell_ok[bsc_pkg::WIN_DEPTH];
  bsc_pkg::sig_vec_t   win_ok;
  bsc_pkg::sig_vec_t   tail_ok;
  bsc_pkg::sig_vec_t   match;
  bsc_pkg::sig_vec_t   hit_flags;
  bsc_pkg::sig_vec_t   hits_now;
  bsc_pkg::kept_t      kept_count;
  bsc_pkg::kept_t      kept_count_next;
  bsc_pkg::char_t      cur;
  bsc_pkg::decide_req_t req;
  logic                accept;
  logic                is_print;
  logic                is_eol;
  logic                take;
  logic                clear;
  logic                free;

  assign accept   = bytes.valid && bytes.ready;
  assign is_print = bytes.raw_byte inside {[bsc_pkg::CHAR_FIRST:bsc_pkg::CHAR_LAST]};
  assign is_eol   = bytes.raw_byte inside {bsc_pkg::CHAR_LF, bsc_pkg::CHAR_CR};
  assign cur      = is_print ? bytes.raw_byte : bsc_pkg::CHAR_SPACE;
  assign take     = accept && bytes.has_byte && (is_print || is_eol)
                    && (kept_count < bsc_pkg::KEPT_W'(bsc_pkg::MAX_BANNER));
  assign clear    = accept && bytes.last;

  for (genvar i = 0; i < bsc_pkg::WIN_DEPTH; i++) begin : g_cell
    bsc_pkg::char_t din;
    if (i == 0) begin : g_head
      assign din = cur;
    end else begin : g_link
      assign din = tap[i-1];
    end
    bsc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (take),
      .clear   (clear),
      .din     (din),
      .pattern (bsc_pkg::cell_ref(i)),
      .dout    (tap[i]),
      .hit_ok  (cell_ok[i])
    );
  end

  always_comb begin
    win_ok = '1;
    for (int i = 0; i < bsc_pkg::WIN_DEPTH; i++) begin
      win_ok = win_ok & cell_ok[i];
    end
    for (int k = 0; k < bsc_pkg::SIG_COUNT; k++) begin
      tail_ok[k] = (cur == bsc_pkg::SIG_TEXT[k][7:0]);
    end
    match           = take ? (tail_ok & win_ok) : '0;
    hits_now        = hit_flags | match;
    kept_count_next = take ? kept_count + 1'b1 : kept_count;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hit_flags  <= '0;
      kept_count <= '0;
    end else begin
      hit_flags  <= hits_now;
      kept_count <= kept_count_next;
    end
  end

  assign req.load = clear;
  assign req.hits = hits_now;
  assign req.kept = kept_count_next;
  assign req.port = bytes.port;

  bsc_decide u_decide (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .free   (free),
    .result (result)
  );

  assign bytes.ready = free;

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    clear |=> result.valid)
    else $error("last beat did not produce a result");

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    clear |=> (hit_flags == '0) && (kept_count == '0) && (tap[0] == '0))
    else $error("state not cleared after last beat");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(kept_count) <= bsc_pkg::MAX_BANNER)
    else $error("kept count beyond banner limit");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !bytes.ready)
    else $error("beat accepted while result stalled");

  a_no_hit_without_chars: assert property (@(posedge clk) disable iff (rst)
    (kept_count == '0) |-> (hit_flags == '0))
    else $error("hit flag set with empty banner");

endmodule

>>> design/bsc_cell.sv
module bsc_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                clear,
  input  bsc_pkg::char_t      din,
  input  bsc_pkg::cell_ref_t  pattern,
  output bsc_pkg::char_t      dout,
  output bsc_pkg::sig_vec_t   hit_ok
);

  bsc_pkg::char_t held;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= '0;
    end else if (advance) begin
      held <= din;
    end
  end

  always_comb begin
    for (int k = 0; k < bsc_pkg::SIG_COUNT; k++) begin
      hit_ok[k] = !pattern.care[k] || (held == pattern.chr[k]);
    end
  end

  assign dout = held;

endmodule

>>> design/bsc_decide.sv
module bsc_decide (
  input  logic                  clk,
  input  logic                  rst,
  input  bsc_pkg::decide_req_t  req,
  output logic                  free,
  bsc_out_if.source             result
);

  bsc_pkg::code_t code_next;
  logic           from_next;
  bsc_pkg::len_t  len_next;

  always_comb begin
    code_next = bsc_pkg::CODE_UNKNOWN;
    from_next = 1'b0;
    if (req.kept != '0) begin
      for (int k = bsc_pkg::SIG_COUNT - 1; k >= 0; k--) begin
        if (req.hits[k]) begin
          code_next = bsc_pkg::SIG_CODE[k];
          from_next = 1'b1;
        end
      end
    end
    if (!from_next) begin
      code_next = bsc_pkg::port_lookup(req.port);
    end
    if (32'(req.kept) > 32'd255) begin
      len_next = '1;
    end else begin
      len_next = bsc_pkg::LEN_W'(req.kept);
    end
  end

  assign free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (req.load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      result.service_code  <= code_next;
      result.from_banner   <= from_next;
      result.banner_length <= len_next;
    end
  end

endmodule

>>> test/tb.sv
module tb;

  typedef struct packed {
    bsc_pkg::char_t raw_byte;
    logic           has_byte;
    logic           last;
    bsc_pkg::port_t port;
  } reply_beat_t;

  typedef struct packed {
    bsc_pkg::code_t service_code;
    logic           from_banner;
    bsc_pkg::len_t  banner_length;
  } service_result_t;

  localparam int N_SIG       = 9;
  localparam int N_PORT      = 14;
  localparam int WIN         = 9;
  localparam int KEEP_MAX    = 200;
  localparam int BEAT_TARGET = 950;
  localparam int MAX_REPORTS = 10;

  localparam int SIG_220  = 0;
  localparam int SIG_RFB  = 5;
  localparam int SIG_SMTP = 6;
  localparam int SIG_SSH  = 7;

  // final character in the low byte
  localparam logic [79:0] SIG_BYTES [N_SIG] = '{
    80'h323230, 80'h417061636865, 80'h485454502F, 80'h4D7953514C,
    80'h506F737467726553514C, 80'h524642, 80'h534D5450, 80'h5353482D,
    80'h6E67696E78
  };
  localparam int SIG_CHARS [N_SIG] = '{3, 6, 5, 5, 10, 3, 4, 4, 5};
  localparam bsc_pkg::code_t SIG_SERVICE [N_SIG] = '{
    bsc_pkg::CODE_FTP, bsc_pkg::CODE_WEB_A, bsc_pkg::CODE_HTTP, bsc_pkg::CODE_SQL_M,
    bsc_pkg::CODE_SQL_P, bsc_pkg::CODE_VNC, bsc_pkg::CODE_SMTP, bsc_pkg::CODE_SSH,
    bsc_pkg::CODE_WEB_N
  };
  localparam bsc_pkg::port_t KNOWN_PORT [N_PORT] = '{
    16'd21, 16'd22, 16'd23, 16'd25, 16'd53, 16'd80, 16'd443,
    16'd3306, 16'd3389, 16'd5432, 16'd5900, 16'd6379, 16'd8080, 16'd27017
  };
  localparam bsc_pkg::code_t KNOWN_SERVICE [N_PORT] = '{
    bsc_pkg::CODE_FTP, bsc_pkg::CODE_SSH, bsc_pkg::CODE_TELNET, bsc_pkg::CODE_SMTP,
    bsc_pkg::CODE_DNS, bsc_pkg::CODE_HTTP, bsc_pkg::CODE_HTTPS, bsc_pkg::CODE_SQL_M,
    bsc_pkg::CODE_RDP, bsc_pkg::CODE_SQL_P, bsc_pkg::CODE_VNC, bsc_pkg::CODE_KV,
    bsc_pkg::CODE_HTTP_ALT, bsc_pkg::CODE_DOC_DB
  };

  logic clk;
  logic rst;

  bsc_in_if  in_if ();
  bsc_out_if out_if ();

  banner_service_classifier u_top (
    .clk    (clk),
    .rst    (rst),
    .bytes  (in_if),
    .result (out_if)
  );

  reply_beat_t       pending_beats [$];
  service_result_t   expected_services [$];
  bsc_pkg::char_t    win_chars [WIN] = '{default: '0};
  bsc_pkg::sig_vec_t sig_hits = '0;
  int                kept_chars = 0;
  int                mismatches = 0;
  int                results_due = 0;
  int                results_seen = 0;
  int                tx_gap;
  int                rx_stall;
  bit                tx_burst = 1'b0;
  bit                rx_burst = 1'b0;
  reply_beat_t       next_beat;
  service_result_t   got_service;
  service_result_t   want_service;

  function automatic void predict_service(input reply_beat_t b);
    bsc_pkg::char_t  ch;
    logic            keep;
    logic            hit;
    service_result_t r;
    ch   = b.raw_byte;
    keep = b.has_byte && ((ch >= bsc_pkg::CHAR_FIRST && ch <= bsc_pkg::CHAR_LAST) ||
                          ch == bsc_pkg::CHAR_LF || ch == bsc_pkg::CHAR_CR);
    if (ch == bsc_pkg::CHAR_LF || ch == bsc_pkg::CHAR_CR) ch = bsc_pkg::CHAR_SPACE;
    if (keep && kept_chars < KEEP_MAX) begin
      for (int k = 0; k < N_SIG; k++) begin
        hit = (SIG_BYTES[k][7:0] == ch);
        for (int i = 0; i < SIG_CHARS[k] - 1; i++) begin
          if (win_chars[i] != SIG_BYTES[k][8*(i+1) +: 8]) hit = 1'b0;
        end
        if (hit) sig_hits[k] = 1'b1;
      end
      for (int i = WIN - 1; i > 0; i--) win_chars[i] = win_chars[i-1];
      win_chars[0] = ch;
      kept_chars++;
    end
    if (b.last) begin
      r.service_code  = bsc_pkg::CODE_UNKNOWN;
      r.from_banner   = 1'b0;
      r.banner_length = bsc_pkg::len_t'(kept_chars);
      if (kept_chars != 0) begin
        for (int k = N_SIG - 1; k >= 0; k--) begin
          if (sig_hits[k]) begin
            r.service_code = SIG_SERVICE[k];
            r.from_banner  = 1'b1;
          end
        end
      end
      if (!r.from_banner) begin
        for (int k = 0; k < N_PORT; k++) begin
          if (KNOWN_PORT[k] == b.port) r.service_code = KNOWN_SERVICE[k];
        end
      end
      expected_services.push_back(r);
      win_chars  = '{default: '0};
      sig_hits   = '0;
      kept_chars = 0;
    end
  endfunction

  function automatic void report_service(input string what, input service_result_t got,
                                         input service_result_t want);
    if (mismatches < MAX_REPORTS) begin
      $display("%s: got code=%0d banner=%0d len=%0d, expected code=%0d banner=%0d len=%0d",
               what, got.service_code, got.from_banner, got.banner_length,
               want.service_code, want.from_banner, want.banner_length);
    end
    mismatches++;
  endfunction

  task automatic push_beat(input bsc_pkg::char_t b, input logic has, input logic last,
                           input bsc_pkg::port_t p);
    reply_beat_t t;
    t.raw_byte = b;
    t.has_byte = has;
    t.last     = last;
    t.port     = p;
    pending_beats.push_back(t);
    if (last) results_due++;
  endtask

  task automatic push_sig(input int k, input bit corrupt);
    int bad;
    bad = corrupt ? $urandom_range(0, SIG_CHARS[k] - 1) : -1;
    for (int i = SIG_CHARS[k] - 1; i >= 0; i--) begin
      push_beat((i == bad) ? bsc_pkg::char_t'($urandom_range(32, 126))
                           : SIG_BYTES[k][8*i +: 8],
                1'b1, 1'b0, bsc_pkg::port_t'($urandom));
    end
  endtask

  task automatic push_banner();
    int             n;
    int             sent;
    int             pick;
    int             k;
    bsc_pkg::port_t p;
    n    = ($urandom_range(0, 99) < 3) ? $urandom_range(195, 215) : $urandom_range(0, 24);
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        k = $urandom_range(0, N_SIG - 1);
        push_sig(k, $urandom_range(0, 4) == 0);
        sent += SIG_CHARS[k];
      end else begin
        case (pick)
          4: begin
            push_beat($urandom_range(0, 1) ? bsc_pkg::CHAR_CR : bsc_pkg::CHAR_LF, 1'b1, 1'b0,
                      bsc_pkg::port_t'($urandom));
          end
          5: begin
            push_beat(bsc_pkg::char_t'($urandom), 1'b1, 1'b0, bsc_pkg::port_t'($urandom));
          end
          6: begin
            push_beat(bsc_pkg::char_t'($urandom), 1'b0, 1'b0, bsc_pkg::port_t'($urandom));
          end
          default: begin
            push_beat(bsc_pkg::char_t'($urandom_range(32, 126)), 1'b1, 1'b0,
                      bsc_pkg::port_t'($urandom));
          end
        endcase
        sent++;
      end
    end
    case ($urandom_range(0, 3))
      0, 1: p = KNOWN_PORT[$urandom_range(0, N_PORT - 1)];
      2: p = bsc_pkg::port_t'($urandom);
      default: p = KNOWN_PORT[$urandom_range(0, N_PORT - 1)] + bsc_pkg::port_t'(1);
    endcase
    push_beat(bsc_pkg::char_t'($urandom), logic'($urandom_range(0, 1)), 1'b1, p);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_service(reply_beat_t'{in_if.raw_byte, in_if.has_byte, in_if.last, in_if.port});
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap != 0) begin
          in_if.valid <= 1'b0;
          tx_gap--;
        end else if (pending_beats.size() != 0) begin
          next_beat = pending_beats.pop_front();
          in_if.raw_byte <= next_beat.raw_byte;
          in_if.has_byte <= next_beat.has_byte;
          in_if.last     <= next_beat.last;
          in_if.port     <= next_beat.port;
          in_if.valid    <= 1'b1;
          if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      rx_stall = $urandom_range(0, 15);
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        got_service = service_result_t'{out_if.service_code, out_if.from_banner,
                                        out_if.banner_length};
        if (expected_services.size() == 0) begin
          report_service("unexpected result", got_service, '0);
        end else begin
          want_service = expected_services.pop_front();
          if (got_service.service_code !== want_service.service_code ||
              got_service.from_banner !== want_service.from_banner ||
              got_service.banner_length !== want_service.banner_length) begin
            report_service("mismatch", got_service, want_service);
          end
        end
        if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (rx_stall != 0) begin
        out_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    in_if.valid     = 1'b0;
    in_if.raw_byte  = '0;
    in_if.has_byte  = 1'b0;
    in_if.last      = 1'b0;
    in_if.port      = '0;
    out_if.ready    = 1'b0;

    // empty reply
    push_beat(8'hFF, 1'b0, 1'b1, 16'd21);
    // signature closed by CR on the last beat
    push_sig(SIG_SSH, 1'b0);
    push_beat(bsc_pkg::CHAR_CR, 1'b1, 1'b1, 16'hFFFF);
    // dropped bytes, LF, last beat without a byte
    push_beat(8'h00, 1'b1, 1'b0, 16'h0000);
    push_beat(8'hFF, 1'b1, 1'b0, 16'hFFFF);
    push_beat(8'h7F, 1'b1, 1'b0, 16'h0000);
    push_beat(8'h09, 1'b1, 1'b0, 16'hFFFF);
    push_sig(SIG_RFB, 1'b0);
    push_beat(bsc_pkg::CHAR_LF, 1'b1, 1'b0, 16'h0000);
    push_beat(8'h55, 1'b0, 1'b1, 16'h0000);
    // two hits, higher priority wins
    push_sig(SIG_SMTP, 1'b0);
    push_sig(SIG_220, 1'b0);
    push_beat(bsc_pkg::CHAR_LAST, 1'b1, 1'b1, 16'd27017);

    while (pending_beats.size() < BEAT_TARGET) push_banner();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (results_seen < results_due) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
